// ===== hdl/command_frame_builder_crc16_defines.svh =====
// Assertion macros shared by the RTL of the command frame builder.
// Included by the top level; depends on nothing else.
`ifndef COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFB_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cfb same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cfb next-cycle check failed");

`endif

// ===== hdl/cfb_pkg.sv =====
// Types, constants and CRC helpers of the command frame builder.
// Used by every module of the block; depends on nothing.
package cfb_pkg;

    localparam int unsigned DATA_WORDS = 6;
    localparam logic [2:0]  LAST_INDEX = 3'd6;

    localparam logic [11:0] NODE_ID_RESET    = 12'd10;
    localparam logic [2:0]  READ_CODE_RESET  = 3'd1;
    localparam logic [2:0]  WRITE_CODE_RESET = 3'd2;

    localparam logic [1:0] REG_NODE_ID    = 2'd0;
    localparam logic [1:0] REG_READ_CODE  = 2'd1;
    localparam logic [1:0] REG_WRITE_CODE = 2'd2;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [11:0] node_id;
        logic [2:0]  read_code;
        logic [2:0]  write_code;
    } cfg_t;

    // Words 0 to 5 of one frame; the CRC word is formed on the way out.
    typedef logic [DATA_WORDS-1:0][15:0] frame_words_t;

    typedef logic [255:0][15:0] crc_table_t;

    function automatic crc_table_t crc_gen_table();
        crc_table_t tbl;
        logic [15:0] c;
        for (int i = 0; i < 256; i++) begin
            c = {i[7:0], 8'h00};
            for (int k = 0; k < 8; k++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_gen_table();

    // Advances the CRC over one word, low byte first, one table step per byte.
    function automatic logic [15:0] crc_word(input logic [15:0] crc, input logic [15:0] w);
        logic [15:0] c;
        c = {crc[7:0], 8'h00} ^ CRC_TABLE[crc[15:8] ^ w[7:0]];
        c = {c[7:0], 8'h00} ^ CRC_TABLE[c[15:8] ^ w[15:8]];
        return c;
    endfunction

endpackage

// ===== hdl/command_frame_builder_crc16.sv =====
// Top level of the command frame builder: configuration registers, front end,
// frame queue and word sequencer. Depends on cfb_pkg and the defines header.
//
// Usage:
// Each request on the s_ channel becomes one seven-word frame on the m_
// channel: two header words, four data words and a CRC-16/XMODEM word.
// One transfer moves one 16-bit word; tlast marks the CRC word.
// With the sequencer idle, the first word of a frame is registered in a queue
// slot and then in the output register before it is valid.
// The output moves one word per cycle while m_tready is high and frames are
// queued, set by the output channel; the CRC takes each header and data word.
// The queue holds QUEUE_DEPTH built frames, so new requests are taken while
// a frame is still being sent; s_tready drops only when the queue is full.
// When the receiver stalls, the current word holds in the output register,
// the sequencer waits and the queue fills behind it.
// Reset (aresetn low, synchronous) empties the queue and the output, and
// loads node_id 10, read_code 1 and write_code 2.
// Configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at once
// and belong in idle periods; indexes above 2 are ignored.
`include "command_frame_builder_crc16_defines.svh"

module command_frame_builder_crc16 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // subnode[3:0], reg_address[15:4], byte_count[19:16], payload[83:20]
    input  logic [87:0] s_tdata,
    // extended[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_word[15:0], word_index[18:16]
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata
);

    logic [11:0] node_id_reg;
    logic [2:0]  read_code_reg;
    logic [2:0]  write_code_reg;
    cfb_pkg::cfg_t cfg;

    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  head_valid;
    cfb_pkg::frame_words_t push_frame;
    cfb_pkg::frame_words_t head_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= cfb_pkg::NODE_ID_RESET;
            read_code_reg  <= cfb_pkg::READ_CODE_RESET;
            write_code_reg <= cfb_pkg::WRITE_CODE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                cfb_pkg::REG_NODE_ID:    node_id_reg    <= cfg_wdata;
                cfb_pkg::REG_READ_CODE:  read_code_reg  <= cfg_wdata[2:0];
                cfb_pkg::REG_WRITE_CODE: write_code_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{node_id: node_id_reg, read_code: read_code_reg,
                   write_code: write_code_reg};

    cfb_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .cfg        (cfg),
        .s_tready   (s_tready),
        .push       (push),
        .frame      (push_frame)
    );

    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    cfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // A word that is not the last is followed at once by the next index.
    `CFB_ASSERT_NEXT(a_word_follows, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[18:16] == 3'($past(m_tdata[18:16]) + 3'd1)))
    // After the CRC word, whatever comes next opens a new frame.
    `CFB_ASSERT_NEXT(a_frame_restarts, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tdata[18:16] == 3'd0))
    // The queue never takes a frame while it is full.
    `CFB_ASSERT_SAME(a_no_push_full, aclk, aresetn, queue_full, !push && !s_tready)

endmodule

// ===== hdl/cfb_front.sv =====
// Front end: takes one request, picks the command and masks the payload,
// and forms words 0 to 5 of the frame. Depends on cfb_pkg.
module cfb_front (
    input  logic                  s_tvalid,
    input  logic [87:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  queue_full,
    input  cfb_pkg::cfg_t         cfg,
    output logic                  s_tready,
    output logic                  push,
    output cfb_pkg::frame_words_t frame
);

    logic [3:0]  subnode;
    logic [11:0] reg_address;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic [63:0] data;
    logic [2:0]  command;

    assign subnode     = s_tdata[3:0];
    assign reg_address = s_tdata[15:4];
    assign byte_count  = s_tdata[19:16];
    assign payload     = s_tdata[83:20];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    assign command = (byte_count != 4'd0) ? cfg.write_code : cfg.read_code;

    // Extended frames pass the payload whole; others keep the low min(byte_count, 8) bytes.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            data[8*b +: 8] = (s_tuser || (byte_count > 4'(b))) ? payload[8*b +: 8] : 8'h00;
        end
    end

    always_comb begin
        frame[0] = {cfg.node_id, subnode};
        frame[1] = {reg_address, command, s_tuser};
        for (int i = 0; i < 4; i++) begin
            frame[2+i] = data[16*i +: 16];
        end
    end

endmodule

// ===== hdl/cfb_queue.sv =====
// Short frame queue between the front end and the word sequencer.
// Depends on cfb_pkg for the frame type.
module cfb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cfb_pkg::frame_words_t push_frame,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output cfb_pkg::frame_words_t head_frame
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cfb_pkg::frame_words_t slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_frame = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ===== hdl/cfb_back.sv =====
// Word sequencer: sends the seven words of the head frame through an output
// register and accumulates the CRC as words are loaded. Depends on cfb_pkg.
module cfb_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  cfb_pkg::frame_words_t head_frame,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tlast
);

    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_word_reg, out_word_next;
    logic [2:0]  out_index_reg;
    logic        load;
    logic        at_crc;
    logic [15:0] cur_word;

    assign at_crc   = (idx_reg == cfb_pkg::LAST_INDEX);
    assign cur_word = at_crc ? crc_reg : head_frame[idx_reg];
    assign load     = head_valid && (!out_valid_reg || m_tready);
    assign pop      = load && at_crc;

    always_comb begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (load) begin
            out_valid_next = 1'b1;
            out_word_next  = cur_word;
            if (at_crc) begin
                idx_next = '0;
                crc_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
                crc_next = cfb_pkg::crc_word(crc_reg, cur_word);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
        if (load) begin
            out_index_reg <= idx_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_index_reg, out_word_reg};
    assign m_tlast  = (out_index_reg == cfb_pkg::LAST_INDEX);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for command_frame_builder_crc16: streams random and
// directed requests, predicts each seven-word frame and its CRC-16/XMODEM word.
// Depends on cfb_pkg and the command_frame_builder_crc16 RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that decodes to no register; writes to it must be dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int FRAME_LEN = 7;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [3:0]  subnode;
        logic [11:0] reg_address;
        logic [3:0]  byte_count;
        logic        extended;
        logic [63:0] payload;
    } request_t;

    typedef struct {
        logic [15:0] frame_word;
        logic [2:0]  word_index;
        logic        last;
    } frame_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;

    request_t      request_q[$];
    frame_word_t   frame_words_due[$];
    cfb_pkg::cfg_t node_cfg;
    request_t      cur_req;
    int            src_gap = 0;
    int            sink_gap = 0;
    int            bad_words = 0;
    bit            quiet = 1'b0;

    command_frame_builder_crc16 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ cfb_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Works out the seven words that one accepted request must produce.
    function automatic void predict_frame(input request_t req);
        logic [15:0] w [FRAME_LEN];
        logic [63:0] data;
        logic [2:0]  cmd;
        logic [15:0] crc;
        frame_word_t fw;
        data = req.payload;
        cmd  = (req.byte_count != 0) ? node_cfg.write_code : node_cfg.read_code;
        if (!req.extended) begin
            if (req.byte_count == 0)
                data = '0;
            else if (req.byte_count < 8)
                data &= (64'd1 << (8 * req.byte_count)) - 64'd1;
        end
        w[0] = {node_cfg.node_id, req.subnode};
        w[1] = {req.reg_address, cmd, req.extended};
        for (int i = 0; i < 4; i++) begin
            w[2 + i] = data[16 * i +: 16];
        end
        crc = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            crc = crc16_byte(crc, w[i][7:0]);
            crc = crc16_byte(crc, w[i][15:8]);
        end
        w[FRAME_LEN - 1] = crc;
        for (int i = 0; i < FRAME_LEN; i++) begin
            fw.frame_word = w[i];
            fw.word_index = 3'(i);
            fw.last       = (i == FRAME_LEN - 1);
            frame_words_due.push_back(fw);
        end
    endfunction

    function automatic request_t make_req(input logic [3:0] sub, input logic [11:0] addr,
                                          input logic [3:0] cnt, input logic ext,
                                          input logic [63:0] pay);
        request_t r;
        r.subnode     = sub;
        r.reg_address = addr;
        r.byte_count  = cnt;
        r.extended    = ext;
        r.payload     = pay;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.subnode     = 4'($urandom);
        r.reg_address = 12'($urandom);
        // Mostly legal byte counts, with a share above eight.
        if ($urandom_range(0, 5) == 0)
            r.byte_count = 4'($urandom_range(9, 15));
        else
            r.byte_count = 4'($urandom_range(0, 8));
        r.extended    = ($urandom_range(0, 3) == 0);
        r.payload     = {$urandom, $urandom};
        return r;
    endfunction

    // Source side: presents queued requests, holds each until its transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                predict_frame(cur_req);
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                cur_req = request_q.pop_front();
                s_tdata <= {4'b0, cur_req.payload, cur_req.byte_count,
                            cur_req.reg_address, cur_req.subnode};
                s_tuser <= cur_req.extended;
                s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 19);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random backpressure and comparison of every word transfer.
    always @(posedge aclk) begin
        frame_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_words_due.size() == 0) begin
                    $error("unexpected frame word %h", m_tdata[15:0]);
                    bad_words++;
                end else begin
                    want = frame_words_due.pop_front();
                    if (m_tdata[15:0] !== want.frame_word) begin
                        $error("frame_word: expected %h, actual %h",
                               want.frame_word, m_tdata[15:0]);
                        bad_words++;
                    end
                    if (m_tdata[18:16] !== want.word_index) begin
                        $error("word_index: expected %0d, actual %0d",
                               want.word_index, m_tdata[18:16]);
                        bad_words++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_tlast);
                        bad_words++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [11:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            cfb_pkg::REG_NODE_ID:    node_cfg.node_id    = val;
            cfb_pkg::REG_READ_CODE:  node_cfg.read_code  = val[2:0];
            cfb_pkg::REG_WRITE_CODE: node_cfg.write_code = val[2:0];
            default: ;
        endcase
    endtask

    // Returns once every queued request has been sent and every word received.
    task automatic drain();
        do
            @(posedge aclk);
        while (request_q.size() != 0 || s_tvalid || frame_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            request_q.push_back(random_request());
        end
    endtask

    initial begin
        node_cfg.node_id    = cfb_pkg::NODE_ID_RESET;
        node_cfg.read_code  = cfb_pkg::READ_CODE_RESET;
        node_cfg.write_code = cfb_pkg::WRITE_CODE_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset configuration.
        request_q.push_back(make_req(4'h0, 12'h000, 4'd0, 1'b0, 64'h0));
        request_q.push_back(make_req(4'hF, 12'hFFF, 4'd0, 1'b0, '1));
        request_q.push_back(make_req(4'hF, 12'hFFF, 4'd8, 1'b0, '1));
        request_q.push_back(make_req(4'h0, 12'h000, 4'd8, 1'b1, '1));
        for (int c = 1; c < 8; c++) begin
            request_q.push_back(make_req(4'(c), 12'(c * 301), 4'(c), 1'b0,
                                         64'hFEDC_BA98_7654_3210));
        end
        request_q.push_back(make_req(4'h3, 12'h123, 4'd9, 1'b0, 64'hA5A5_A5A5_A5A5_A5A5));
        request_q.push_back(make_req(4'hC, 12'hC00, 4'd15, 1'b0, 64'h5A5A_5A5A_5A5A_5A5A));
        request_q.push_back(make_req(4'h7, 12'h7FF, 4'd0, 1'b1, 64'h0123_4567_89AB_CDEF));
        request_q.push_back(make_req(4'h9, 12'h800, 4'd3, 1'b1, '1));
        request_q.push_back(make_req(4'h5, 12'hAAA, 4'd8, 1'b0, 64'h5555_5555_5555_5555));
        request_q.push_back(make_req(4'hA, 12'h555, 4'd4, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA));
        drain();

        write_register(cfb_pkg::REG_NODE_ID, 12'hFFF);
        write_register(cfb_pkg::REG_READ_CODE, 12'h007);
        write_register(cfb_pkg::REG_WRITE_CODE, 12'h000);
        push_random(50);
        drain();

        write_register(cfb_pkg::REG_NODE_ID, 12'h000);
        write_register(cfb_pkg::REG_READ_CODE, 12'h000);
        write_register(cfb_pkg::REG_WRITE_CODE, 12'hFFF);
        write_register(REG_UNUSED, 12'hFFF);
        push_random(50);
        drain();

        write_register(cfb_pkg::REG_NODE_ID, 12'($urandom));
        write_register(cfb_pkg::REG_READ_CODE, 12'($urandom));
        write_register(cfb_pkg::REG_WRITE_CODE, 12'($urandom));
        push_random(55);
        drain();

        // Closing stretch at full rate on both sides.
        quiet = 1'b1;
        write_register(cfb_pkg::REG_NODE_ID, 12'($urandom));
        write_register(cfb_pkg::REG_READ_CODE, 12'($urandom));
        write_register(cfb_pkg::REG_WRITE_CODE, 12'($urandom));
        push_random(55);
        drain();

        if (bad_words == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cfb_pkg.sv
hdl/cfb_front.sv
hdl/cfb_queue.sv
hdl/cfb_back.sv
hdl/command_frame_builder_crc16.sv
verif/tb.sv
